// ===== rtl/core/graph_depth_first_walk_defines.svh =====
// Assertion macros for the graph walk block.
// Used by the top level; no other dependencies.
`ifndef GRAPH_DEPTH_FIRST_WALK_DEFINES_SVH
`define GRAPH_DEPTH_FIRST_WALK_DEFINES_SVH
`ifndef SYNTHESIS
`define GDFW_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("gdfw check failed");
`define GDFW_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("gdfw never failed");
`else
`define GDFW_ASSERT_IMPL(label, clk, rst_n, prop)
`define GDFW_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/gdfw_pkg.sv =====
// Package for the graph walk block: sizes, codes, colors and controller states.
// No dependencies.
package gdfw_pkg;
	localparam int MAX_NODES_DEF   = 64;
	localparam int MAX_ENTRIES_DEF = 512;
	localparam int CFG_W           = 7;
	localparam int CFG_IDX_W       = 1;
	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_DIRECTED   = 1'b1;
	localparam logic KIND_EDGE      = 1'b0;
	localparam logic KIND_RUN       = 1'b1;

	typedef enum logic [1:0] {
		COLOR_WHITE = 2'd0,
		COLOR_GRAY  = 2'd1,
		COLOR_BLACK = 2'd2
	} color_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LINK_A,
		ST_LINK_RD,
		ST_LINK_B,
		ST_ROOT,
		ST_ROOT_CHK,
		ST_TOP,
		ST_TOP_CHK,
		ST_EDGE,
		ST_CHILD,
		ST_EMIT,
		ST_CLEAR
	} state_t;
endpackage

// ===== rtl/core/graph_depth_first_walk.sv =====
// Top level of the graph walk block: edge store, node table and controller.
// Depends on gdfw_pkg and graph_depth_first_walk_defines.svh.
//
// A dropped edge word never raises busy; a stored edge word keeps busy high while
// its link is written, longer when undirected as two links are stored, since the
// list head sits in the node memory and is read before each link is written. A run
// word keeps busy high from the cycle after acceptance while it scans node indices
// for new trees, follows each stored entry (with no child check when its target is
// not below the count), finishes each node, emits one result per node and then
// clears the node table. Results pass through the emit_v_s1 stage and the output
// registers, one per cycle with done strobed; the receiver cannot stall them. The
// walk stack is the chain of parent links, each node keeps its own list cursor.
// After reset the same clearing pass holds busy high until the node table is clear.
`include "graph_depth_first_walk_defines.svh"
module graph_depth_first_walk #(
	parameter int MAX_NODES   = gdfw_pkg::MAX_NODES_DEF,
	parameter int MAX_ENTRIES = gdfw_pkg::MAX_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gdfw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gdfw_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic                           kind,
	input  logic [5:0]                     from_node,
	input  logic [5:0]                     to_node,
	output logic                           done,
	output logic [5:0]                     node_index,
	output logic                           has_parent,
	output logic [5:0]                     parent_node,
	output logic [7:0]                     discover_time,
	output logic [7:0]                     finish_time,
	output logic                           edges_dropped,
	output logic                           last
);
	import gdfw_pkg::*;

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef struct packed {
		logic [NW-1:0] target;
		logic [EW-1:0] nxt;
		logic          nxt_v;
	} entry_t;
	typedef struct packed {
		logic [1:0]    color;
		logic          pv;
		logic [NW-1:0] parent;
		logic [7:0]    disc;
		logic [7:0]    fin;
		logic [EW-1:0] head;
		logic          head_v;
		logic [EW-1:0] cur;
		logic          cur_v;
	} node_t;

	entry_t ent_mem [MAX_ENTRIES];
	node_t  node_mem [MAX_NODES];
	entry_t ent_rd_q;
	node_t  node_rd_q;

	logic [6:0]    node_count_q;
	logic          directed_q;
	state_t        state_q, state_d;
	logic [CW-1:0] used_q;
	logic [7:0]    time_q;
	logic          drop_q;
	logic [NW-1:0] f_q, t_q;
	logic          pair_q;
	logic [6:0]    i_q;
	logic [NW-1:0] u_q;
	logic [NW-1:0] v_q;
	node_t         top_q;
	logic          emit_v_s1;
	logic [6:0]    idx_s1;
	logic          drop_s1;
	logic [6:0]    n_act;
	logic          edge_ok;
	logic          v_in;

	logic          ent_we;
	logic [EW-1:0] ent_waddr;
	logic [EW-1:0] ent_raddr;
	entry_t        ent_wd;
	logic          node_we;
	logic [NW-1:0] node_waddr;
	logic [NW-1:0] node_raddr;
	node_t         node_wd;

	assign n_act = (node_count_q > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count_q;
	assign busy  = (state_q != ST_IDLE);
	assign edge_ok = ({1'b0, from_node} < n_act) && ({1'b0, to_node} < n_act) &&
		(32'(used_q) + (directed_q ? 32'd1 : 32'd2) <= 32'(MAX_ENTRIES));
	assign v_in = (7'(ent_rd_q.target) < n_act);

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wd;
		ent_rd_q <= ent_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_waddr] <= node_wd;
		node_rd_q <= node_mem[node_raddr];
	end

	always_comb begin
		state_d = state_q;
		ent_we = 1'b0;
		ent_waddr = EW'(used_q);
		ent_raddr = node_rd_q.cur;
		ent_wd = '0;
		node_we = 1'b0;
		node_waddr = u_q;
		node_raddr = u_q;
		node_wd = node_rd_q;
		case (state_q)
			ST_IDLE: begin
				node_raddr = from_node[NW-1:0];
				if (start && kind == KIND_EDGE && edge_ok) state_d = ST_LINK_A;
				if (start && kind == KIND_RUN) state_d = ST_ROOT;
			end
			ST_LINK_A: begin
				ent_we = 1'b1;
				ent_wd.target = t_q;
				ent_wd.nxt = node_rd_q.head;
				ent_wd.nxt_v = node_rd_q.head_v;
				node_we = 1'b1;
				node_waddr = f_q;
				node_wd.head = EW'(used_q);
				node_wd.head_v = 1'b1;
				state_d = pair_q ? ST_LINK_RD : ST_IDLE;
			end
			ST_LINK_RD: begin
				node_raddr = t_q;
				state_d = ST_LINK_B;
			end
			ST_LINK_B: begin
				ent_we = 1'b1;
				ent_wd.target = f_q;
				ent_wd.nxt = node_rd_q.head;
				ent_wd.nxt_v = node_rd_q.head_v;
				node_we = 1'b1;
				node_waddr = t_q;
				node_wd.head = EW'(used_q);
				node_wd.head_v = 1'b1;
				state_d = ST_IDLE;
			end
			ST_ROOT: begin
				node_raddr = i_q[NW-1:0];
				if (i_q >= n_act) begin
					state_d = (n_act == 7'd0) ? ST_CLEAR : ST_EMIT;
				end else begin
					state_d = ST_ROOT_CHK;
				end
			end
			ST_ROOT_CHK: begin
				if (node_rd_q.color == COLOR_WHITE) begin
					node_we = 1'b1;
					node_waddr = i_q[NW-1:0];
					node_wd.color = COLOR_GRAY;
					node_wd.disc = time_q + 8'd1;
					node_wd.cur = node_rd_q.head;
					node_wd.cur_v = node_rd_q.head_v;
					state_d = ST_TOP;
				end else begin
					state_d = ST_ROOT;
				end
			end
			ST_TOP: begin
				state_d = ST_TOP_CHK;
			end
			ST_TOP_CHK: begin
				if (node_rd_q.cur_v) begin
					state_d = ST_EDGE;
				end else begin
					node_we = 1'b1;
					node_wd.color = COLOR_BLACK;
					node_wd.fin = time_q + 8'd1;
					state_d = node_rd_q.pv ? ST_TOP : ST_ROOT;
				end
			end
			ST_EDGE: begin
				node_we = 1'b1;
				node_wd = top_q;
				node_wd.cur = ent_rd_q.nxt;
				node_wd.cur_v = ent_rd_q.nxt_v;
				node_raddr = ent_rd_q.target;
				state_d = v_in ? ST_CHILD : ST_TOP;
			end
			ST_CHILD: begin
				if (node_rd_q.color == COLOR_WHITE) begin
					node_we = 1'b1;
					node_waddr = v_q;
					node_wd.color = COLOR_GRAY;
					node_wd.pv = 1'b1;
					node_wd.parent = u_q;
					node_wd.disc = time_q + 8'd1;
					node_wd.cur = node_rd_q.head;
					node_wd.cur_v = node_rd_q.head_v;
				end
				state_d = ST_TOP;
			end
			ST_EMIT: begin
				node_raddr = i_q[NW-1:0];
				if (i_q + 7'd1 == n_act) state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				node_we = 1'b1;
				node_waddr = i_q[NW-1:0];
				node_wd = '0;
				if (i_q == 7'(MAX_NODES - 1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			node_count_q <= 7'd64;
			directed_q <= 1'b0;
			used_q <= '0;
			time_q <= '0;
			drop_q <= 1'b0;
			f_q <= '0;
			t_q <= '0;
			pair_q <= 1'b0;
			i_q <= '0;
			u_q <= '0;
			v_q <= '0;
			top_q <= '0;
			emit_v_s1 <= 1'b0;
			idx_s1 <= '0;
			drop_s1 <= 1'b0;
			done <= 1'b0;
			node_index <= '0;
			has_parent <= 1'b0;
			parent_node <= '0;
			discover_time <= '0;
			finish_time <= '0;
			edges_dropped <= 1'b0;
			last <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CFG_NODE_COUNT) node_count_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_DIRECTED) directed_q <= cfg_data[0];

			emit_v_s1 <= (state_q == ST_EMIT);
			idx_s1 <= i_q;
			drop_s1 <= drop_q;
			done <= emit_v_s1;
			node_index <= idx_s1[5:0];
			has_parent <= node_rd_q.pv;
			parent_node <= node_rd_q.pv ? 6'(node_rd_q.parent) : 6'd0;
			discover_time <= node_rd_q.disc;
			finish_time <= node_rd_q.fin;
			edges_dropped <= drop_s1;
			last <= (idx_s1 + 7'd1 == n_act);

			case (state_q)
				ST_IDLE: begin
					if (start && kind == KIND_EDGE) begin
						f_q <= from_node[NW-1:0];
						t_q <= to_node[NW-1:0];
						pair_q <= !directed_q;
						if (!edge_ok) drop_q <= 1'b1;
					end
					if (start && kind == KIND_RUN) i_q <= '0;
				end
				ST_LINK_A, ST_LINK_B: begin
					used_q <= used_q + CW'(1);
				end
				ST_ROOT: begin
					if (i_q >= n_act) i_q <= '0;
				end
				ST_ROOT_CHK: begin
					if (node_rd_q.color == COLOR_WHITE) begin
						time_q <= time_q + 8'd1;
						u_q <= i_q[NW-1:0];
					end else begin
						i_q <= i_q + 7'd1;
					end
				end
				ST_TOP_CHK: begin
					top_q <= node_rd_q;
					if (!node_rd_q.cur_v) begin
						time_q <= time_q + 8'd1;
						if (node_rd_q.pv) u_q <= node_rd_q.parent;
						else i_q <= i_q + 7'd1;
					end
				end
				ST_EDGE: begin
					v_q <= ent_rd_q.target;
				end
				ST_CHILD: begin
					if (node_rd_q.color == COLOR_WHITE) begin
						time_q <= time_q + 8'd1;
						u_q <= v_q;
					end
				end
				ST_EMIT: begin
					if (i_q + 7'd1 == n_act) i_q <= '0;
					else i_q <= i_q + 7'd1;
				end
				ST_CLEAR: begin
					i_q <= i_q + 7'd1;
					if (state_d == ST_IDLE) begin
						used_q <= '0;
						time_q <= '0;
						drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	`GDFW_ASSERT_NEVER(a_used_bound, clk, arst_n, 32'(used_q) > MAX_ENTRIES)
	`GDFW_ASSERT_IMPL(a_done_busy, clk, arst_n, done |-> busy)
	`GDFW_ASSERT_NEVER(a_time_bound, clk, arst_n, 32'(time_q) > 2 * MAX_NODES)
endmodule
